// File: rtl/rmte_pkg.sv
// Shared types, constants and lookup functions for the rotation matrix to Euler angle unit.
`timescale 1ns / 1ps
package rmte_pkg;

  // Field widths.
  localparam int ElemW    = 32;
  localparam int AngW     = 32;
  localparam int OpW      = 33;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAxisSeq     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntrinsic   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRightHanded = 2'd2;

  // Middle angle kinds.
  localparam logic [1:0] MidAcos  = 2'd0;
  localparam logic [1:0] MidAsin  = 2'd1;
  localparam logic [1:0] MidNasin = 2'd2;

  // Angle constants in Q3.29 and the gimbal threshold in Q2.30.
  localparam logic signed [OpW-1:0] AngPi     = 33'sd1686629713;
  localparam logic signed [OpW-1:0] AngHalfPi = 33'sd843314857;
  localparam logic signed [OpW-1:0] GimbalLim = 33'sd107375;
  localparam logic signed [31:0]    OneQ30    = 32'sd1073741824;
  localparam logic [3:0]            NumSeq    = 4'd12;

  // Pipeline geometry.
  localparam int CordicIters  = 30;
  localparam int CordicStages = CordicIters + 1;
  localparam int SqrtStages   = 31;
  localparam int FrontStages  = 3;
  localparam int PipeDepth    = FrontStages + SqrtStages + CordicStages;

  // Arc tangent table, round(atan(2^-i) * 2^29).
  localparam logic [31:0] AtanTab [CordicIters] = '{
    32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
    32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575,
    32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384,
    32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128,
    32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
  };

  // One matrix element reference, optionally negated.
  typedef struct packed {
    logic       neg;
    logic [3:0] idx;
  } elem_t;

  typedef struct packed {
    logic [1:0] mid_kind;
    elem_t      mid_el;
    elem_t      chk_el;
    elem_t      lock_y;
    elem_t      lock_x;
    elem_t      first_y;
    elem_t      first_x;
    elem_t      third_y;
    elem_t      third_x;
  } plan_t;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]            mid_kind;
    logic signed [31:0]    v;
    logic                  lock;
    logic signed [OpW-1:0] y0;
    logic signed [OpW-1:0] x0;
    logic signed [OpW-1:0] y2;
    logic signed [OpW-1:0] x2;
  } side_t;

  // Side data that rides along the arc tangent pipelines.
  typedef struct packed {
    logic neg_mid;
    logic lock;
  } tail_t;

  function automatic elem_t el(input int code);
    elem_t e;
    e.neg = (code < 0);
    e.idx = (code < 0) ? 4'(-code - 1) : 4'(code - 1);
    return e;
  endfunction

  function automatic plan_t mk(input logic [1:0] kind, input int mid, input int chk,
                               input int ly, input int lx, input int fy, input int fx,
                               input int ty, input int tx);
    plan_t p;
    p.mid_kind = kind;
    p.mid_el   = el(mid);
    p.chk_el   = el(chk);
    p.lock_y   = el(ly);
    p.lock_x   = el(lx);
    p.first_y  = el(fy);
    p.first_x  = el(fx);
    p.third_y  = el(ty);
    p.third_x  = el(tx);
    return p;
  endfunction

  // Element pairs for each axis sequence.
  function automatic plan_t plan_lookup(input logic [3:0] seq);
    plan_t p;
    case (seq)
      4'd0:    p = mk(MidAcos,  1, 7,  6, 5,  2, -3,  4,  7);
      4'd1:    p = mk(MidAcos,  1, 7, -8, 9,  3,  2,  7, -4);
      4'd2:    p = mk(MidAsin,  7, 5,  6, 5, -8,  9, -4,  1);
      4'd3:    p = mk(MidNasin, 4, 6, -8, 9,  6,  5,  7,  1);
      4'd4:    p = mk(MidNasin, 3, 9, -4, 5,  2,  1,  6,  9);
      4'd5:    p = mk(MidAcos,  9, 7, -4, 5,  8,  7,  6, -3);
      4'd6:    p = mk(MidAcos,  9, 7,  2, 1,  7, -8,  3,  6);
      4'd7:    p = mk(MidAsin,  6, 9,  2, 1, -4,  5, -3,  9);
      4'd8:    p = mk(MidAcos,  5, 8,  7, 9,  6, -4,  8,  2);
      4'd9:    p = mk(MidAsin,  2, 5,  7, 9, -3,  1, -8,  5);
      4'd10:   p = mk(MidNasin, 8, 9, -3, 1,  7,  9,  2,  5);
      4'd11:   p = mk(MidAcos,  5, 6, -3, 1,  4,  6,  2, -8);
      default: p = mk(MidAcos,  1, 1,  1, 1,  1,  1,  1,  1);
    endcase
    return p;
  endfunction

  // Sequence used when the rotation is read as intrinsic.
  function automatic logic [3:0] rev_seq(input logic [3:0] seq);
    logic [3:0] r;
    case (seq)
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd9;
      4'd4:    r = 4'd2;
      4'd7:    r = 4'd10;
      4'd9:    r = 4'd3;
      4'd10:   r = 4'd7;
      default: r = seq;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rmte_if.sv
// Stream and configuration interfaces of the rotation matrix to Euler angle unit.
`timescale 1ns / 1ps
interface rmte_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  input ready);
  modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

interface rmte_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_first;
  logic signed [31:0] angle_second;
  logic signed [31:0] angle_third;
  modport source (output valid, angle_first, angle_second, angle_third, input ready);
  modport sink   (input valid, angle_first, angle_second, angle_third, output ready);
endinterface

interface rmte_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rmte_pkg::CfgIdxW-1:0]      index;
  logic [rmte_pkg::CfgDataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rotation_matrix_to_euler_unit.sv
// Top level: rotation matrix to three Euler angles, fully pipelined.
//
//   Port    Direction  Payload
//   in_i    sink       e00 .. e22, signed Q2.30 matrix elements
//   out_o   source     angle_first, angle_second, angle_third, signed Q3.29 radians
//   cfg_i   sink       index (0 axis sequence, 1 intrinsic, 2 right handed), data
//
// One matrix can be taken every cycle while the pipeline is not stalled. Its path to
// the output register runs through the input, select and square stages, 31 square
// root stages and 31 arc tangent stages. Reset clears the valid bits and sets the
// configuration to sequence 0, extrinsic and right handed. The pipeline stops only
// when its last stage holds a result and the output register is still waiting; all stages hold then.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rmte_in_if.sink    in_i,
  rmte_out_if.source out_o,
  rmte_cfg_if.sink   cfg_i
);

  localparam int D  = rmte_pkg::PipeDepth;
  localparam int SQ = rmte_pkg::SqrtStages;
  localparam int CS = rmte_pkg::CordicStages;

  // Configuration registers.
  logic [3:0] axis_seq_q;
  logic       intrinsic_q;
  logic       right_handed_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_seq_q     <= 4'd0;
      intrinsic_q    <= 1'b0;
      right_handed_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rmte_pkg::CfgAxisSeq:     axis_seq_q     <= cfg_i.data[3:0];
        rmte_pkg::CfgIntrinsic:   intrinsic_q    <= cfg_i.data[0];
        rmte_pkg::CfgRightHanded: right_handed_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Flow control: valid bits advance with the data.
  logic [D-1:0] vld_q;
  logic         en;
  logic         out_free;
  logic         in_xfer;

  assign out_free  = !out_o.valid || out_o.ready;
  assign en        = !(vld_q[D-1] && !out_free);
  assign in_i.ready = en;
  assign in_xfer   = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[D-2:0], in_xfer};
    end
  end

  // Stage A: register the matrix.
  logic [8:0][31:0] mat_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mat_q <= {in_i.e22, in_i.e21, in_i.e20, in_i.e12, in_i.e11, in_i.e10,
                in_i.e02, in_i.e01, in_i.e00};
    end
  end

  // Stage B: choose elements for the sequence, clamp, gimbal check.
  rmte_pkg::plan_t plan;
  rmte_pkg::side_t side_b_d, side_b_q;
  logic [3:0]      seq_eff;
  logic signed [31:0] mid_raw;
  logic signed [rmte_pkg::OpW-1:0] chk;

  function automatic logic signed [rmte_pkg::OpW-1:0] pick(input logic [8:0][31:0] m,
                                                           input rmte_pkg::elem_t e);
    logic signed [rmte_pkg::OpW-1:0] v;
    v = {m[e.idx][31], m[e.idx]};
    return e.neg ? -v : v;
  endfunction

  always_comb begin
    seq_eff = intrinsic_q ? rmte_pkg::rev_seq(axis_seq_q) : axis_seq_q;
    plan    = rmte_pkg::plan_lookup(seq_eff);
    mid_raw = mat_q[plan.mid_el.idx];
    chk     = pick(mat_q, plan.chk_el);
    side_b_d.mid_kind = plan.mid_kind;
    if (mid_raw > rmte_pkg::OneQ30) begin
      side_b_d.v = rmte_pkg::OneQ30;
    end else if (mid_raw < -rmte_pkg::OneQ30) begin
      side_b_d.v = -rmte_pkg::OneQ30;
    end else begin
      side_b_d.v = mid_raw;
    end
    side_b_d.lock = (chk < rmte_pkg::GimbalLim) && (chk > -rmte_pkg::GimbalLim);
    if (side_b_d.lock) begin
      side_b_d.y0 = pick(mat_q, plan.lock_y);
      side_b_d.x0 = pick(mat_q, plan.lock_x);
    end else begin
      side_b_d.y0 = pick(mat_q, plan.first_y);
      side_b_d.x0 = pick(mat_q, plan.first_x);
    end
    side_b_d.y2 = pick(mat_q, plan.third_y);
    side_b_d.x2 = pick(mat_q, plan.third_x);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q <= side_b_d;
    end
  end

  // Stage C: radicand 1 - v^2 in unsigned Q1.60.
  logic signed [63:0] vsq;
  logic [60:0]        rad_q;
  rmte_pkg::side_t    side_c_q;
  assign vsq = side_b_q.v * side_b_q.v;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q    <= 61'(64'd1 << 60) - vsq[60:0];
      side_c_q <= side_b_q;
    end
  end

  // Square root, with the side data delayed alongside.
  logic [30:0]     root;
  rmte_pkg::side_t side_s_q [SQ];

  rmte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_s_q[0] <= side_c_q;
      for (int k = 1; k < SQ; k++) begin
        side_s_q[k] <= side_s_q[k-1];
      end
    end
  end

  // Arc tangent operands for the middle angle.
  rmte_pkg::side_t side_s;
  logic signed [rmte_pkg::OpW-1:0] s_op, v_op, mid_y, mid_x;
  rmte_pkg::tail_t tail_d;
  assign side_s = side_s_q[SQ-1];
  assign s_op   = {2'b00, root};
  assign v_op   = {side_s.v[31], side_s.v};
  assign mid_y  = (side_s.mid_kind == rmte_pkg::MidAcos) ? s_op : v_op;
  assign mid_x  = (side_s.mid_kind == rmte_pkg::MidAcos) ? v_op : s_op;
  assign tail_d.neg_mid = (side_s.mid_kind == rmte_pkg::MidNasin);
  assign tail_d.lock    = side_s.lock;

  // Three arc tangent pipelines.
  logic signed [31:0] z0, z1, z2;

  rmte_cordic u_cordic_first (
    .clk_i (clk_i), .en_i (en), .y_i (side_s.y0), .x_i (side_s.x0), .z_o (z0)
  );
  rmte_cordic u_cordic_mid (
    .clk_i (clk_i), .en_i (en), .y_i (mid_y), .x_i (mid_x), .z_o (z1)
  );
  rmte_cordic u_cordic_third (
    .clk_i (clk_i), .en_i (en), .y_i (side_s.y2), .x_i (side_s.x2), .z_o (z2)
  );

  rmte_pkg::tail_t tail_q [CS];
  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail_d;
      for (int k = 1; k < CS; k++) begin
        tail_q[k] <= tail_q[k-1];
      end
    end
  end

  // Final: gimbal zero, swap, handedness and unknown sequences.
  logic signed [31:0] a0, a1, a2, f0, f1, f2;
  always_comb begin
    a0 = z0;
    a1 = tail_q[CS-1].neg_mid ? -z1 : z1;
    a2 = tail_q[CS-1].lock ? 32'sd0 : z2;
    if (intrinsic_q) begin
      f0 = a2;
      f2 = a0;
    end else begin
      f0 = a0;
      f2 = a2;
    end
    f1 = a1;
    if (!right_handed_q) begin
      f0 = -f0;
      f1 = -f1;
      f2 = -f2;
    end
    if (axis_seq_q >= rmte_pkg::NumSeq) begin
      f0 = '0;
      f1 = '0;
      f2 = '0;
    end
  end

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] ang0_q, ang1_q, ang2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= vld_q[D-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      ang0_q <= f0;
      ang1_q <= f1;
      ang2_q <= f2;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.angle_first  = ang0_q;
  assign out_o.angle_second = ang1_q;
  assign out_o.angle_third  = ang2_q;

endmodule

// File: rtl/rmte_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmte_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] rad_i,
  output logic [30:0] root_o
);

  logic [61:0] n_q [rmte_pkg::SqrtStages];
  logic [61:0] r_q [rmte_pkg::SqrtStages];

  for (genvar k = 0; k < rmte_pkg::SqrtStages; k++) begin : g_stage
    localparam logic [61:0] Bit = 62'd1 << (2 * (rmte_pkg::SqrtStages - 1 - k));
    logic [61:0] n_in, r_in, trial, n_d, r_d;

    // Take the previous stage, or the radicand at the head.
    if (k == 0) begin : g_head
      assign n_in = {1'b0, rad_i};
      assign r_in = '0;
    end else begin : g_body
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    // Restoring step for this bit position.
    always_comb begin
      trial = r_in + Bit;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign root_o = r_q[rmte_pkg::SqrtStages-1][30:0];

endmodule

// File: rtl/rmte_cordic.sv
// Pipelined four-quadrant arc tangent by CORDIC vectoring, one iteration per stage.
`timescale 1ns / 1ps
module rmte_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [rmte_pkg::OpW-1:0]   y_i,
  input  logic signed [rmte_pkg::OpW-1:0]   x_i,
  output logic signed [rmte_pkg::AngW-1:0]  z_o
);

  localparam int N = rmte_pkg::CordicIters;

  logic signed [63:0]            x_q [N+1];
  logic signed [63:0]            y_q [N+1];
  logic signed [rmte_pkg::OpW-1:0] z_q [N+1];
  logic                          zero_q [N+1];

  // Front stage: fold the left half plane and scale up.
  logic signed [rmte_pkg::OpW:0] xs, ys, xr, yr;
  logic signed [rmte_pkg::OpW-1:0] zr;
  always_comb begin
    xs = {x_i[rmte_pkg::OpW-1], x_i};
    ys = {y_i[rmte_pkg::OpW-1], y_i};
    xr = xs;
    yr = ys;
    zr = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        xr = ys;
        yr = -xs;
        zr = rmte_pkg::AngHalfPi;
      end else begin
        xr = -ys;
        yr = xs;
        zr = -rmte_pkg::AngHalfPi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= 64'(xr) <<< 28;
      y_q[0]    <= 64'(yr) <<< 28;
      z_q[0]    <= zr;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // Vectoring iterations.
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [63:0] dx, dy;
    logic signed [rmte_pkg::OpW-1:0] ang;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign ang = $signed({1'b0, rmte_pkg::AtanTab[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ang;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ang;
        end
      end
    end
  end

  // Saturate to half a turn; a zero vector gives zero.
  always_comb begin
    if (zero_q[N]) begin
      z_o = '0;
    end else if (z_q[N] > rmte_pkg::AngPi) begin
      z_o = rmte_pkg::AngPi[rmte_pkg::AngW-1:0];
    end else if (z_q[N] < -rmte_pkg::AngPi) begin
      z_o = -(rmte_pkg::AngPi[rmte_pkg::AngW-1:0]);
    end else begin
      z_o = z_q[N][rmte_pkg::AngW-1:0];
    end
  end

endmodule
